// ===== src/tpf_pkg.sv =====
// Shared types, constants and state codes for the tabulated pair-force block.
package tpf_pkg;

  localparam int unsigned NumTypesDef = 8;
  localparam int unsigned NumStepsDef = 256;

  localparam logic [19:0] WidthRst = 20'd384000;
  localparam logic [19:0] HeightRst = 20'd256000;
  localparam logic [23:0] StepRst = 24'd16384;

  localparam logic signed [23:0] V24Max = 24'sh7FFFFF;
  localparam logic signed [23:0] V24Min = -24'sh800000;

  typedef enum logic [1:0] {
    ModeWrite = 2'd0,
    ModeShift = 2'd1,
    ModeScale = 2'd2,
    ModeQuery = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegStep   = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         type_a;
    logic [2:0]         type_b;
    logic [19:0]        pos_ax;
    logic [19:0]        pos_ay;
    logic [19:0]        pos_bx;
    logic [19:0]        pos_by;
    logic [15:0]        radius;
    logic [7:0]         bin_index;
    logic signed [23:0] value;
  } req_t;

  typedef struct packed {
    logic signed [23:0] force_x;
    logic signed [23:0] force_y;
    logic               no_force;
  } res_t;

  typedef enum logic [3:0] {
    StIdle,
    StWrap,
    StSquare,
    StSqrt,
    StBin,
    StRead,
    StProj,
    StRowRead,
    StRowCalc,
    StRowWrite,
    StDone
  } state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic wrap;
    logic square;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic tab_read;
    logic tab_write;
    logic row_calc;
    logic row_write;
    logic proj_init;
    logic proj_step;
    logic emit;
  } cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic [1:0] mode;
    logic       types_ok;
    logic       bin_ok;
    logic       zero_delta;
    logic       zero_denom;
    logic       bin_past;
    logic       iter_last;
    logic       row_last;
  } sts_t;

endpackage

// ===== src/tabulated_pair_force_torus.sv =====
// Top level of the tabulated pair-force lookup on a torus.
// Steps: a row shift or scale reads, computes and writes each bin of the row in turn; a query
// runs 22 root steps, 39 bin divider steps and 47 projection steps.
// One request at a time: busy drops in the strobe cycle, and a new request is taken only in idle.
// The receiver cannot stall: result_valid_o is high for exactly one cycle.
// Reset clears the sequencer and restores the world and step registers.
module tabulated_pair_force_torus #(
  parameter int unsigned NumTypes = tpf_pkg::NumTypesDef,
  parameter int unsigned NumSteps = tpf_pkg::NumStepsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  tpf_pkg::req_t req_i,
  output logic          result_valid_o,
  output tpf_pkg::res_t result_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [23:0]   cfg_data_i
);

  tpf_pkg::cmd_t cmd;
  tpf_pkg::sts_t sts;

  tpf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tpf_datapath #(
    .NumTypes(NumTypes),
    .NumSteps(NumSteps)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_o     (result_o),
    .valid_o   (result_valid_o)
  );

endmodule

// ===== src/tpf_ctrl.sv =====
// Sequencer for table writes, row walks and force queries.
module tpf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tpf_pkg::sts_t sts_i,
  output tpf_pkg::cmd_t cmd_o
);

  tpf_pkg::state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpf_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Choose the next state and drive commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = (state_q != tpf_pkg::StIdle);
    case (state_q)
      tpf_pkg::StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = tpf_pkg::StWrap;
        end
      end
      tpf_pkg::StWrap: begin
        case (sts_i.mode)
          tpf_pkg::ModeWrite: begin
            if (sts_i.types_ok && sts_i.bin_ok) cmd_o.tab_write = 1'b1;
            state_d = tpf_pkg::StDone;
          end
          tpf_pkg::ModeShift, tpf_pkg::ModeScale: begin
            state_d = sts_i.types_ok ? tpf_pkg::StRowRead : tpf_pkg::StDone;
          end
          default: begin
            cmd_o.wrap = 1'b1;
            state_d = tpf_pkg::StSquare;
          end
        endcase
      end
      tpf_pkg::StSquare: begin
        if (!sts_i.types_ok || sts_i.zero_delta || sts_i.zero_denom) begin
          state_d = tpf_pkg::StDone;
        end else begin
          cmd_o.square = 1'b1;
          state_d = tpf_pkg::StSqrt;
          cmd_o.sqrt_init = 1'b1;
        end
      end
      tpf_pkg::StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.iter_last) begin
          state_d = tpf_pkg::StBin;
          cmd_o.div_init = 1'b1;
        end
      end
      tpf_pkg::StBin: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.iter_last) state_d = tpf_pkg::StRead;
      end
      tpf_pkg::StRead: begin
        if (sts_i.bin_past) begin
          state_d = tpf_pkg::StDone;
        end else begin
          cmd_o.tab_read = 1'b1;
          state_d = tpf_pkg::StProj;
          cmd_o.proj_init = 1'b1;
        end
      end
      tpf_pkg::StProj: begin
        cmd_o.proj_step = 1'b1;
        if (sts_i.iter_last) state_d = tpf_pkg::StDone;
      end
      tpf_pkg::StRowRead: begin
        cmd_o.tab_read = 1'b1;
        state_d = tpf_pkg::StRowCalc;
      end
      tpf_pkg::StRowCalc: begin
        cmd_o.row_calc = 1'b1;
        state_d = tpf_pkg::StRowWrite;
      end
      tpf_pkg::StRowWrite: begin
        cmd_o.row_write = 1'b1;
        state_d = sts_i.row_last ? tpf_pkg::StDone : tpf_pkg::StRowRead;
      end
      tpf_pkg::StDone: begin
        cmd_o.emit = 1'b1;
        state_d = tpf_pkg::StIdle;
      end
      default: state_d = tpf_pkg::StIdle;
    endcase
  end

endmodule

// ===== src/tpf_datapath.sv =====
// Datapath: registers, force table, square root, divider and row arithmetic.
module tpf_datapath #(
  parameter int unsigned NumTypes = tpf_pkg::NumTypesDef,
  parameter int unsigned NumSteps = tpf_pkg::NumStepsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tpf_pkg::req_t req_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [23:0]   cfg_data_i,
  input  tpf_pkg::cmd_t cmd_i,
  output tpf_pkg::sts_t sts_o,
  output tpf_pkg::res_t res_o,
  output logic          valid_o
);

  localparam int unsigned TypeW = (NumTypes > 1) ? $clog2(NumTypes) : 1;
  localparam int unsigned StepW = $clog2(NumSteps);
  localparam int unsigned Depth = NumTypes * NumTypes * NumSteps;
  localparam int unsigned AddrW = $clog2(Depth);

  // Configuration registers
  logic [19:0] width_q, height_q;
  logic [23:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tpf_pkg::WidthRst;
      height_q <= tpf_pkg::HeightRst;
      step_q   <= tpf_pkg::StepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpf_pkg::RegWidth:  width_q  <= cfg_data_i[19:0];
        tpf_pkg::RegHeight: height_q <= cfg_data_i[19:0];
        tpf_pkg::RegStep:   step_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request registers
  tpf_pkg::req_t req_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  logic types_ok;
  assign types_ok = ({2'b0, req_q.type_a} < 5'(NumTypes))
                 && ({2'b0, req_q.type_b} < 5'(NumTypes));

  logic [AddrW-1:0] row_base;
  assign row_base = AddrW'((TypeW'(req_q.type_a) * NumTypes + TypeW'(req_q.type_b))
                           * NumSteps);

  // Wrapped deltas
  logic signed [21:0] dx_q, dy_q;
  logic signed [21:0] dx_raw, dy_raw, dx_w, dy_w;
  logic signed [21:0] hw, hh;

  assign dx_raw = $signed({2'b0, req_q.pos_ax}) - $signed({2'b0, req_q.pos_bx});
  assign dy_raw = $signed({2'b0, req_q.pos_ay}) - $signed({2'b0, req_q.pos_by});
  assign hw = $signed({3'b0, width_q[19:1]});
  assign hh = $signed({3'b0, height_q[19:1]});

  // Apply the torus wrap to one axis
  function automatic logic signed [21:0] wrap_f(input logic signed [21:0] d,
                                                 input logic signed [21:0] h,
                                                 input logic [19:0] s);
    logic signed [21:0] r;
    r = d;
    if (r > h) r = r - $signed({2'b0, s});
    if (r < -h) r = r + $signed({2'b0, s});
    return r;
  endfunction

  assign dx_w = wrap_f(dx_raw, hw, width_q);
  assign dy_w = wrap_f(dy_raw, hh, height_q);

  // Denominator radius * step
  logic [39:0] denom_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wrap) begin
      dx_q <= dx_w;
      dy_q <= dy_w;
      denom_q <= 40'(req_q.radius) * 40'(step_q);
    end
  end

  // Squares, one multiply each per register
  logic [43:0] sq_q;
  logic [21:0] adx, ady;
  assign adx = dx_q[21] ? 22'(-dx_q) : 22'(dx_q);
  assign ady = dy_q[21] ? 22'(-dy_q) : 22'(dy_q);

  // Iteration counter shared by root, divide and projection
  logic [5:0] cnt_q;

  // Square root, one result bit per cycle (radicand up to 44 bits)
  logic [45:0] rem_q;
  logic [21:0] root_q;
  logic [43:0] rad_q;
  logic [45:0] trial;
  logic [45:0] rem_sh;
  assign rem_sh = {rem_q[43:0], rad_q[43:42]};
  assign trial = {root_q, 2'b01};

  // Bin divider: (dist << 16) / denom, 38-bit dividend, restoring
  logic [37:0] quo_q;
  logic [40:0] drem_q;
  logic [40:0] drem_sh;
  assign drem_sh = {drem_q[39:0], quo_q[37]};

  // Projection divider: |d*f| / dist for both axes at once
  logic [45:0] px_q, py_q;
  logic [22:0] prx_q, pry_q;
  logic [22:0] prx_sh, pry_sh;
  logic        sx_q, sy_q;
  assign prx_sh = {prx_q[21:0], px_q[45]};
  assign pry_sh = {pry_q[21:0], py_q[45]};

  // Force table
  logic signed [23:0] mem [Depth];
  logic signed [23:0] rd_q;
  logic [StepW-1:0]   k_q;
  logic [AddrW-1:0]   rd_addr;
  logic [AddrW-1:0]   wr_addr;
  logic signed [23:0] wr_data;
  logic               wr_en;
  logic signed [23:0] row_q;

  assign rd_addr = cmd_i.proj_init ? AddrW'(row_base + AddrW'(quo_q[StepW-1:0]))
                                   : AddrW'(row_base + AddrW'(k_q));
  assign wr_en = cmd_i.tab_write | cmd_i.row_write;
  assign wr_addr = cmd_i.tab_write ? AddrW'(row_base + AddrW'(req_q.bin_index))
                                   : AddrW'(row_base + AddrW'(k_q));
  assign wr_data = cmd_i.tab_write ? req_q.value : row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.tab_read) rd_q <= mem[rd_addr];
  end

  // Row arithmetic with saturation
  logic signed [24:0] sum;
  logic signed [47:0] prod;
  logic signed [31:0] fl;
  logic signed [23:0] row_d;
  assign sum = 25'(rd_q) + 25'(req_q.value);
  assign prod = 48'(rd_q) * 48'(req_q.value);
  assign fl = 32'(prod >>> 16);

  always_comb begin
    if (req_q.mode == tpf_pkg::ModeShift) begin
      if (sum > 25'(tpf_pkg::V24Max)) row_d = tpf_pkg::V24Max;
      else if (sum < 25'(tpf_pkg::V24Min)) row_d = tpf_pkg::V24Min;
      else row_d = sum[23:0];
    end else begin
      if (fl > 32'(tpf_pkg::V24Max)) row_d = tpf_pkg::V24Max;
      else if (fl < 32'(tpf_pkg::V24Min)) row_d = tpf_pkg::V24Min;
      else row_d = fl[23:0];
    end
  end

  // Saturating sign restore of a magnitude quotient
  function automatic logic signed [23:0] sat_f(input logic [45:0] q, input logic neg);
    logic signed [23:0] r;
    if (!neg) r = (q > 46'(tpf_pkg::V24Max)) ? tpf_pkg::V24Max : $signed(q[23:0]);
    else r = (q > 46'd8388608) ? tpf_pkg::V24Min : $signed(24'(-q[23:0]));
    return r;
  endfunction

  // Iterative datapath sequencing
  logic        valid_q;
  tpf_pkg::res_t res_q;
  logic [45:0] fmag;

  // Force magnitude, kept unsigned so the most negative entry stays positive
  assign fmag = {22'd0, rd_q[23] ? 24'(-rd_q) : 24'(rd_q)};

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sq_q <= 44'(adx) * 44'(adx) + 44'(ady) * 44'(ady);
    end
    if (cmd_i.load) k_q <= '0;
    if (cmd_i.row_calc) row_q <= row_d;
    if (cmd_i.row_write) k_q <= k_q + 1'b1;
    if (cmd_i.sqrt_init) begin
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      if (cnt_q == 6'd0) begin
        rad_q <= {sq_q[41:0], 2'b00};
        rem_q <= 46'(sq_q[43:42]) >= 46'd1 ? 46'(sq_q[43:42]) - 46'd1 : 46'(sq_q[43:42]);
        root_q <= 22'(sq_q[43:42] != 2'b00);
      end else begin
        rad_q <= {rad_q[41:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[20:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[20:0], 1'b0};
        end
      end
    end
    if (cmd_i.div_init) begin
      drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (cnt_q == 6'd0) begin
        quo_q <= {root_q, 16'd0};
      end else begin
        if (drem_sh >= {1'b0, denom_q}) begin
          drem_q <= drem_sh - {1'b0, denom_q};
          quo_q  <= {quo_q[36:0], 1'b1};
        end else begin
          drem_q <= drem_sh;
          quo_q  <= {quo_q[36:0], 1'b0};
        end
      end
    end
    if (cmd_i.proj_init) begin
      prx_q <= '0;
      pry_q <= '0;
    end
    if (cmd_i.proj_step) begin
      if (cnt_q == 6'd0) begin
        px_q <= 46'(adx) * fmag;
        py_q <= 46'(ady) * fmag;
        sx_q <= dx_q[21] ^ rd_q[23];
        sy_q <= dy_q[21] ^ rd_q[23];
      end else begin
        if (prx_sh >= {1'b0, root_q}) begin
          prx_q <= prx_sh - {1'b0, root_q};
          px_q  <= {px_q[44:0], 1'b1};
        end else begin
          prx_q <= prx_sh;
          px_q  <= {px_q[44:0], 1'b0};
        end
        if (pry_sh >= {1'b0, root_q}) begin
          pry_q <= pry_sh - {1'b0, root_q};
          py_q  <= {py_q[44:0], 1'b1};
        end else begin
          pry_q <= pry_sh;
          py_q  <= {py_q[44:0], 1'b0};
        end
      end
    end
    // Restart the counter for a new phase, else advance it on every step
    if (cmd_i.sqrt_init || cmd_i.div_init || cmd_i.proj_init) begin
      cnt_q <= 6'd0;
    end else if (cmd_i.sqrt_step || cmd_i.div_step || cmd_i.proj_step) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  logic got_force_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) got_force_q <= 1'b0;
    else if (cmd_i.load) got_force_q <= 1'b0;
    else if (cmd_i.proj_init) got_force_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.no_force <= (req_q.mode == tpf_pkg::ModeQuery) && !got_force_q;
      if (got_force_q && req_q.mode == tpf_pkg::ModeQuery) begin
        res_q.force_x <= sat_f(px_q, sx_q);
        res_q.force_y <= sat_f(py_q, sy_q);
      end else begin
        res_q.force_x <= '0;
        res_q.force_y <= '0;
      end
    end
  end

  assign res_o = res_q;
  assign valid_o = valid_q;

  // Status to the controller
  logic iter_last;
  always_comb begin
    iter_last = 1'b0;
    if (cmd_i.sqrt_step) iter_last = (cnt_q == 6'd21);
    if (cmd_i.div_step)  iter_last = (cnt_q == 6'd38);
    if (cmd_i.proj_step) iter_last = (cnt_q == 6'd46);
  end

  assign sts_o.mode       = req_q.mode;
  assign sts_o.types_ok   = types_ok;
  assign sts_o.bin_ok     = ({2'b0, req_q.bin_index} < 10'(NumSteps));
  assign sts_o.zero_delta = (dx_q == '0) && (dy_q == '0);
  assign sts_o.zero_denom = (denom_q == '0);
  assign sts_o.bin_past   = (quo_q >= 38'(NumSteps));
  assign sts_o.iter_last  = iter_last;
  assign sts_o.row_last   = (k_q == StepW'(NumSteps - 1));

endmodule
